@@ rtl/afc_pkg.sv @@
// ----------------------------------------------------------------------------
// afc_pkg - box frustum containment shared definitions
// Widths, matrix and product grid types, register indexes and reset values.
// ----------------------------------------------------------------------------
package afc_pkg;

  localparam int NUM_REGS  = 6;
  localparam int COEF_W    = 32;
  localparam int PROD_W    = 64;
  localparam int FRAC_BITS = 16;

  // all four clip tests passed
  localparam logic [3:0] ALL_FLAGS = 4'hf;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PROD_W:0]   xy_t;
  typedef logic signed [PROD_W+1:0] clip_t;
  typedef logic signed [PROD_W+2:0] test_t;

  typedef struct packed {
    coef_t min_x;
    coef_t min_y;
    coef_t min_z;
    coef_t max_x;
    coef_t max_y;
    coef_t max_z;
  } box_t;

  // rows 0..2, columns 0..3
  typedef logic [2:0][3:0][COEF_W-1:0] mat_t;
  // row, axis
  typedef logic [2:0][2:0][PROD_W-1:0] prod_grid_t;
  // per row, column 3 times w
  typedef logic [2:0][PROD_W-1:0]      row_prod_t;
  // row, xy corner select
  typedef logic [2:0][3:0][PROD_W:0]   xy_grid_t;
  // row, z select
  typedef logic [2:0][1:0][PROD_W:0]   zc_grid_t;
  // row, corner
  typedef logic [2:0][7:0][PROD_W+1:0] clip_grid_t;

  typedef enum logic [2:0] {
    REG_ROW_X_LO = 3'd0,
    REG_ROW_X_HI = 3'd1,
    REG_ROW_Y_LO = 3'd2,
    REG_ROW_Y_HI = 3'd3,
    REG_ROW_Z_LO = 3'd4,
    REG_ROW_Z_HI = 3'd5
  } reg_idx_t;

  // listed from index 5 down to index 0
  localparam logic [NUM_REGS-1:0][63:0] REG_RESET = {
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000
  };

endpackage

@@ rtl/afc_mul.sv @@
// ----------------------------------------------------------------------------
// afc_mul - product stage
// Multiplies every box coordinate by the matching matrix entry of each row.
// ----------------------------------------------------------------------------
module afc_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  afc_pkg::box_t      in_box,
  input  afc_pkg::mat_t      mat,
  output logic               out_valid,
  input  logic               out_ready,
  output afc_pkg::prod_grid_t prod_lo,
  output afc_pkg::prod_grid_t prod_hi,
  output afc_pkg::row_prod_t  offset
);
  import afc_pkg::*;

  coef_t      lo_c [3];
  coef_t      hi_c [3];
  prod_grid_t prod_lo_nxt, prod_hi_nxt;
  prod_grid_t prod_lo_r, prod_hi_r;
  row_prod_t  offset_nxt, offset_r;
  logic       valid_r;

  assign lo_c[0] = in_box.min_x;
  assign lo_c[1] = in_box.min_y;
  assign lo_c[2] = in_box.min_z;
  assign hi_c[0] = in_box.max_x;
  assign hi_c[1] = in_box.max_y;
  assign hi_c[2] = in_box.max_z;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int a = 0; a < 3; a++) begin
        prod_lo_nxt[r][a] = prod_t'(coef_t'(mat[r][a])) * prod_t'(lo_c[a]);
        prod_hi_nxt[r][a] = prod_t'(coef_t'(mat[r][a])) * prod_t'(hi_c[a]);
      end
      // column 3 times w = 1.0 is a sign-extended shift
      offset_nxt[r] = {{(PROD_W-COEF_W-FRAC_BITS){mat[r][3][COEF_W-1]}},
                       mat[r][3], {FRAC_BITS{1'b0}}};
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      prod_lo_r <= prod_lo_nxt;
      prod_hi_r <= prod_hi_nxt;
      offset_r  <= offset_nxt;
    end
  end

  assign out_valid = valid_r;
  assign prod_lo   = prod_lo_r;
  assign prod_hi   = prod_hi_r;
  assign offset    = offset_r;

endmodule

@@ rtl/afc_sum.sv @@
// ----------------------------------------------------------------------------
// afc_sum - corner accumulation stages
// First level adds x and y products and z product plus offset, second level
// combines them into clip x, y and z for all eight corners.
// ----------------------------------------------------------------------------
module afc_sum (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  afc_pkg::prod_grid_t prod_lo,
  input  afc_pkg::prod_grid_t prod_hi,
  input  afc_pkg::row_prod_t  offset,
  output logic                out_valid,
  input  logic                out_ready,
  output afc_pkg::clip_grid_t clip
);
  import afc_pkg::*;

  xy_grid_t   xy_nxt, xy_r;
  zc_grid_t   zc_nxt, zc_r;
  clip_grid_t clip_nxt, clip_r;
  logic       v2_r, v3_r;
  logic       rdy2, rdy3;

  // corner select bit 0 picks x, bit 1 picks y
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      xy_nxt[r][0] = xy_t'(prod_t'(prod_lo[r][0])) + xy_t'(prod_t'(prod_lo[r][1]));
      xy_nxt[r][1] = xy_t'(prod_t'(prod_hi[r][0])) + xy_t'(prod_t'(prod_lo[r][1]));
      xy_nxt[r][2] = xy_t'(prod_t'(prod_lo[r][0])) + xy_t'(prod_t'(prod_hi[r][1]));
      xy_nxt[r][3] = xy_t'(prod_t'(prod_hi[r][0])) + xy_t'(prod_t'(prod_hi[r][1]));
      zc_nxt[r][0] = xy_t'(prod_t'(prod_lo[r][2])) + xy_t'(prod_t'(offset[r]));
      zc_nxt[r][1] = xy_t'(prod_t'(prod_hi[r][2])) + xy_t'(prod_t'(offset[r]));
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int zs = 0; zs < 2; zs++) begin
        for (int q = 0; q < 4; q++) begin
          clip_nxt[r][zs*4+q] = clip_t'(xy_t'(xy_r[r][q])) + clip_t'(xy_t'(zc_r[r][zs]));
        end
      end
    end
  end

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign in_ready = rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_r <= in_valid;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && in_valid) begin
      xy_r <= xy_nxt;
      zc_r <= zc_nxt;
    end
    if (rdy3 && v2_r) begin
      clip_r <= clip_nxt;
    end
  end

  assign out_valid = v3_r;
  assign clip      = clip_r;

endmodule

@@ rtl/afc_clip.sv @@
// ----------------------------------------------------------------------------
// afc_clip - clip test and result stage
// Runs the four strict clip tests on every corner and holds the result.
// ----------------------------------------------------------------------------
module afc_clip (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  afc_pkg::clip_grid_t clip,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_fully_inside
);
  import afc_pkg::*;

  logic inside_nxt;
  logic inside_r;
  logic valid_r;

  always_comb begin : p_test
    test_t      cx, cy, cz;
    logic [3:0] flags;
    inside_nxt = 1'b1;
    for (int k = 0; k < 8; k++) begin
      cx = test_t'(clip_t'(clip[0][k]));
      cy = test_t'(clip_t'(clip[1][k]));
      cz = test_t'(clip_t'(clip[2][k]));
      flags[3] = (cz - cx) > test_t'(0);
      flags[2] = (cz + cx) > test_t'(0);
      flags[1] = (cz - cy) > test_t'(0);
      flags[0] = (cz + cy) > test_t'(0);
      if (flags != ALL_FLAGS) begin
        inside_nxt = 1'b0;
      end
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      inside_r <= inside_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_fully_inside = inside_r;

endmodule

@@ rtl/aabb_frustum_containment_test_core.sv @@
// ----------------------------------------------------------------------------
// aabb_frustum_containment_test_core - box in frustum containment test
// Transforms the eight corners of an axis-aligned box by matrix rows 0 to 2
// and flags the box when every corner lies strictly inside the clip planes.
// ----------------------------------------------------------------------------
// usage
//   input channel: one box request (min and max corners, signed Q16.16) per
//   in_valid with in_stall low. result channel: one fully_inside bit per box,
//   in request order, taken when out_valid is high and out_stall is low.
//   config port: cfg_we writes cfg_wdata into matrix register cfg_index
//   (0..5); other indexes are dropped. write only while no box is in flight.
// pipeline and throughput
//   an accepted box passes the product register, two adder registers, then the
//   clip test output register that drives out_valid. one box per cycle sustained
//   while out_stall is low; the 18 parallel 32x32 multipliers and the 66-bit
//   corner adders set the stage depth.
// reset
//   rst_n low clears all stage valid bits and loads the identity-like matrix
//   reset values.
// stall
//   out_stall holds the result register; empty stages behind it keep filling,
//   and in_stall rises only once every stage holds a box.
// ----------------------------------------------------------------------------
module aabb_frustum_containment_test_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  afc_pkg::coef_t      in_min_x,
  input  afc_pkg::coef_t      in_min_y,
  input  afc_pkg::coef_t      in_min_z,
  input  afc_pkg::coef_t      in_max_x,
  input  afc_pkg::coef_t      in_max_y,
  input  afc_pkg::coef_t      in_max_z,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_fully_inside,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_wdata
);
  import afc_pkg::*;

  logic [NUM_REGS-1:0][63:0] regs_r;
  mat_t       mat;
  box_t       box;
  prod_grid_t prod_lo, prod_hi;
  row_prod_t  offset;
  clip_grid_t clip;
  logic       mul_ready, mul_valid;
  logic       sum_ready, sum_valid;
  logic       clip_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= REG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_X_LO: regs_r[REG_ROW_X_LO] <= cfg_wdata;
        REG_ROW_X_HI: regs_r[REG_ROW_X_HI] <= cfg_wdata;
        REG_ROW_Y_LO: regs_r[REG_ROW_Y_LO] <= cfg_wdata;
        REG_ROW_Y_HI: regs_r[REG_ROW_Y_HI] <= cfg_wdata;
        REG_ROW_Z_LO: regs_r[REG_ROW_Z_LO] <= cfg_wdata;
        REG_ROW_Z_HI: regs_r[REG_ROW_Z_HI] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // even column in the low word, odd column in the high word
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int h = 0; h < 2; h++) begin
        for (int w = 0; w < 2; w++) begin
          mat[r][2*h+w] = regs_r[2*r+h][COEF_W*w +: COEF_W];
        end
      end
    end
  end

  assign box.min_x = in_min_x;
  assign box.min_y = in_min_y;
  assign box.min_z = in_min_z;
  assign box.max_x = in_max_x;
  assign box.max_y = in_max_y;
  assign box.max_z = in_max_z;

  afc_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (mul_ready),
    .in_box    (box),
    .mat       (mat),
    .out_valid (mul_valid),
    .out_ready (sum_ready),
    .prod_lo   (prod_lo),
    .prod_hi   (prod_hi),
    .offset    (offset)
  );

  afc_sum u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mul_valid),
    .in_ready  (sum_ready),
    .prod_lo   (prod_lo),
    .prod_hi   (prod_hi),
    .offset    (offset),
    .out_valid (sum_valid),
    .out_ready (clip_ready),
    .clip      (clip)
  );

  afc_clip u_clip (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (sum_valid),
    .in_ready         (clip_ready),
    .clip             (clip),
    .out_valid        (out_valid),
    .out_ready        (!out_stall),
    .out_fully_inside (out_fully_inside)
  );

  assign in_stall = !mul_ready;

endmodule

@@ rtl/afc_checker.sv @@
// ----------------------------------------------------------------------------
// afc_checker - port level checks for the containment core
// Watches the core's ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module afc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic                out_fully_inside
);

  // a held result stays up
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_fully_inside))
    else $error("result changed while stalled");

  // back pressure only when the result stage is blocked
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with result stage free");

  a_reset_empty : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind aabb_frustum_containment_test_core afc_checker u_afc_checker (.*);
